FILE: src/pcf_pkg.sv
// Shared types and constants for the cubic path flattener.
// No dependencies.
`timescale 1ns / 1ps
package pcf_pkg;
	localparam int MaxDepth  = 5;
	localparam int CoordW    = 24;
	localparam int TolW      = 48;
	localparam int LvlW      = 3;
	localparam int SpW       = 3;

	typedef enum logic [2:0] {
		OP_MOVE  = 3'd0,
		OP_LINE  = 3'd1,
		OP_CUBIC = 3'd2,
		OP_CLOSE = 3'd3,
		OP_END   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_POINT  = 2'd0,
		KIND_OPEN   = 2'd1,
		KIND_CLOSED = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_PRE,
		ST_PT,
		ST_EVAL,
		ST_MUL,
		ST_DEC,
		ST_POP
	} state_t;

	typedef struct packed {
		logic load;      // capture curve from item and current point
		logic mul;       // register cross-product partials
		logic split;     // push right half, continue with left
		logic pop;       // read right half from stack
		logic pop_ld;    // load popped data into the working curve
	} dp_cmd_t;

	typedef struct packed {
		logic flat;       // piece is final (flat, depth, or stack full)
		logic stack_empty;
	} dp_sts_t;

	function automatic logic signed [CoordW-1:0] mid(
		input logic signed [CoordW-1:0] a, input logic signed [CoordW-1:0] b);
		logic signed [CoordW:0] s;
		s = {a[CoordW-1], a} + {b[CoordW-1], b};
		return s[CoordW:1];
	endfunction
endpackage

FILE: src/pcf_datapath.sv
// Subdivision datapath: working curve, split stack memory, flatness test.
// Depends on pcf_pkg.
`timescale 1ns / 1ps
module pcf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcf_pkg::dp_cmd_t              cmd,
	output pcf_pkg::dp_sts_t              sts,
	input  logic [pcf_pkg::TolW-1:0]      tol,
	input  logic signed [pcf_pkg::CoordW-1:0] in_c [8],
	output logic signed [pcf_pkg::CoordW-1:0] end_x,
	output logic signed [pcf_pkg::CoordW-1:0] end_y
);
	import pcf_pkg::*;

	logic signed [CoordW-1:0] c_q [8];
	logic [LvlW-1:0] lvl_q;
	logic [SpW-1:0] sp_q;
	// stack: 8 coords plus level per entry
	logic [8*CoordW+LvlW-1:0] mem [MaxDepth];
	logic [8*CoordW+LvlW-1:0] rd_q;
	logic signed [2*CoordW+1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic signed [CoordW:0] dx3, dy3, d1x, d1y, d2x, d2y;
	logic signed [2*CoordW+2:0] f1, f2;
	logic [2*CoordW+2:0] a1, a2, fm;
	logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy, abx, aby, bcx, bcy, mx, my;

	assign dx3 = c_q[6] - c_q[0];
	assign dy3 = c_q[7] - c_q[1];
	assign d1x = c_q[2] - c_q[0];
	assign d1y = c_q[3] - c_q[1];
	assign d2x = c_q[4] - c_q[0];
	assign d2y = c_q[5] - c_q[1];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_s1 <= d1x * dy3;
			p2_s1 <= d1y * dx3;
			p3_s1 <= d2x * dy3;
			p4_s1 <= d2y * dx3;
		end
	end

	always_comb begin
		f1 = p1_s1 - p2_s1;
		f2 = p3_s1 - p4_s1;
		a1 = f1[2*CoordW+2] ? (~f1 + 1'b1) : f1;
		a2 = f2[2*CoordW+2] ? (~f2 + 1'b1) : f2;
		fm = (a1 > a2) ? a1 : a2;
	end

	assign sts.flat = (fm <= {3'b0, tol}) || (lvl_q >= LvlW'(MaxDepth))
		|| (sp_q >= SpW'(MaxDepth));
	assign sts.stack_empty = (sp_q == '0);

	assign ax  = mid(c_q[0], c_q[2]);
	assign ay  = mid(c_q[1], c_q[3]);
	assign bx  = mid(c_q[2], c_q[4]);
	assign by  = mid(c_q[3], c_q[5]);
	assign cx  = mid(c_q[4], c_q[6]);
	assign cy  = mid(c_q[5], c_q[7]);
	assign abx = mid(ax, bx);
	assign aby = mid(ay, by);
	assign bcx = mid(bx, cx);
	assign bcy = mid(by, cy);
	assign mx  = mid(abx, bcx);
	assign my  = mid(aby, bcy);

	always_ff @(posedge clk) begin
		if (cmd.split)
			mem[sp_q[SpW-1:0]] <= {c_q[7], c_q[6], cy, cx, bcy, bcx, my, mx,
				LvlW'(lvl_q + 1'b1)};
		if (cmd.pop)
			rd_q <= mem[SpW'(sp_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			lvl_q <= '0;
		end else if (cmd.load) begin
			sp_q <= '0;
			lvl_q <= '0;
		end else if (cmd.split) begin
			sp_q <= sp_q + 1'b1;
			lvl_q <= lvl_q + 1'b1;
		end else if (cmd.pop) begin
			sp_q <= sp_q - 1'b1;
		end else if (cmd.pop_ld) begin
			lvl_q <= rd_q[LvlW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) c_q[i] <= in_c[i];
		end else if (cmd.split) begin
			c_q[2] <= ax;  c_q[3] <= ay;
			c_q[4] <= abx; c_q[5] <= aby;
			c_q[6] <= mx;  c_q[7] <= my;
		end else if (cmd.pop_ld) begin
			for (int i = 0; i < 8; i++)
				c_q[i] <= rd_q[LvlW + i*CoordW +: CoordW];
		end
	end

	assign end_x = c_q[6];
	assign end_y = c_q[7];
endmodule

FILE: src/pcf_ctrl.sv
// Control state machine: path element decode, contour bookkeeping,
// subdivision sequencing and output register. Depends on pcf_pkg.
`timescale 1ns / 1ps
module pcf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    in_op,
	input  logic signed [pcf_pkg::CoordW-1:0] in_p [6],
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [pcf_pkg::CoordW-1:0] out_x,
	output logic signed [pcf_pkg::CoordW-1:0] out_y,
	output logic [1:0]                    out_kind,
	output logic                          out_last,
	output pcf_pkg::dp_cmd_t              cmd,
	input  pcf_pkg::dp_sts_t              sts,
	output logic signed [pcf_pkg::CoordW-1:0] cv [8],
	input  logic signed [pcf_pkg::CoordW-1:0] end_x,
	input  logic signed [pcf_pkg::CoordW-1:0] end_y
);
	import pcf_pkg::*;

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic signed [CoordW-1:0] p_q [6];
	logic signed [CoordW-1:0] cur_x_q, cur_y_q;
	logic has_cur_q;
	logic [1:0] cnt_q;
	logic ov_q;
	logic free;
	logic emit;
	logic signed [CoordW-1:0] ex, ey;
	logic [1:0] ek;
	logic el;
	logic mark_n;

	assign free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign cv[0] = cur_x_q; assign cv[1] = cur_y_q;
	assign cv[2] = p_q[0];  assign cv[3] = p_q[1];
	assign cv[4] = p_q[2];  assign cv[5] = p_q[3];
	assign cv[6] = p_q[4];  assign cv[7] = p_q[5];

	// move / end of path need an open marker when contour count is nonzero
	assign mark_n = (cnt_q != 2'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (in_op)
					OP_MOVE, OP_CLOSE, OP_END: state_d = ST_MARK;
					OP_LINE:  state_d = ST_PRE;
					OP_CUBIC: state_d = has_cur_q ? ST_PRE : ST_IDLE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_MARK: if (free || !mark_n)
				state_d = (op_q == OP_MOVE) ? ST_PT : ST_IDLE;
			ST_PRE: if (free || !(has_cur_q && cnt_q == 2'd0))
				state_d = (op_q == OP_LINE) ? ST_PT : ST_MUL;
			ST_PT:  if (free) state_d = ST_IDLE;
			ST_MUL: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!sts.flat) state_d = ST_MUL;
				else if (free) state_d = sts.stack_empty ? ST_IDLE : ST_POP;
			end
			ST_POP: state_d = ST_DEC;
			ST_DEC: state_d = ST_MUL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		emit = 1'b0;
		ex = '0; ey = '0; ek = KIND_POINT; el = 1'b0;
		case (state_q)
			ST_MARK: begin
				emit = mark_n && free;
				ek = (op_q == OP_CLOSE && cnt_q == 2'd2) ? KIND_CLOSED : KIND_OPEN;
				el = (op_q != OP_MOVE);
			end
			ST_PRE: begin
				emit = has_cur_q && cnt_q == 2'd0 && free;
				ex = cur_x_q; ey = cur_y_q;
				cmd.load = (op_q == OP_CUBIC);
			end
			ST_PT: begin
				emit = free;
				ex = p_q[0]; ey = p_q[1]; el = 1'b1;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_EVAL: begin
				cmd.split = !sts.flat;
				emit = sts.flat && free;
				ex = end_x; ey = end_y; el = sts.stack_empty;
				cmd.pop = sts.flat && free && !sts.stack_empty;
			end
			ST_DEC: cmd.pop_ld = 1'b1;
			default: ;
		endcase
		if (state_q == ST_PRE && !(has_cur_q && cnt_q == 2'd0) && op_q == OP_CUBIC)
			cmd.load = 1'b1;
		if (state_q == ST_PRE && !free && has_cur_q && cnt_q == 2'd0)
			cmd.load = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			has_cur_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= emit || (ov_q && !out_ready);
			if (emit && ek == KIND_POINT && cnt_q != 2'd2) cnt_q <= cnt_q + 1'b1;
			case (state_q)
				ST_MARK: if (free || !mark_n) begin
					cnt_q <= 2'd0;
					has_cur_q <= (op_q == OP_MOVE);
					if (op_q == OP_MOVE) begin
						cur_x_q <= p_q[0]; cur_y_q <= p_q[1];
					end
					if (op_q == OP_END) begin
						cur_x_q <= '0; cur_y_q <= '0;
					end
				end
				ST_PT: if (free) begin
					cur_x_q <= p_q[0]; cur_y_q <= p_q[1];
					has_cur_q <= 1'b1;
				end
				ST_EVAL: if (sts.flat && free && sts.stack_empty) begin
					cur_x_q <= p_q[4]; cur_y_q <= p_q[5];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= in_op;
			for (int i = 0; i < 6; i++) p_q[i] <= in_p[i];
		end
		if (emit) begin
			out_x <= ex; out_y <= ey; out_kind <= ek; out_last <= el;
		end
	end

	assign out_valid = ov_q;
endmodule

FILE: src/path_cubic_flattener.sv
// Top level of the cubic path flattener: ports, tdata packing, and the
// controller/datapath pair. Depends on pcf_pkg, pcf_ctrl, pcf_datapath.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_* takes one path element per beat: move, line,
//   cubic, close or end of path. Master channel m_axis_* delivers
//   flattened points and contour-end markers; tuser holds the kind, tlast
//   marks the final result of one input element.
//   cfg_we/cfg_wdata writes the flatness tolerance (reset 65536); write it
//   only while the block is idle.
// Sequencing: one element at a time, starting with the accept step. Move
//   takes a marker step and a point step, line a start-point step and a
//   point step, close and end of path a marker step; an ignored element
//   only the accept. A cubic takes a product step then a compare step per
//   visited subdivision node plus a pop and a load step per stack pop.
// Latency: a result appears on the master side the cycle after it is
//   produced; the output register lets work continue while it waits.
// Reset: clears the current point, contour count, stack pointer and the
//   output valid; the tolerance returns to its reset value.
// Stall: when m_axis_tready is low, hold the result and stall the
//   sequencer at the next emitting step; s_axis_tready stays low.
module path_cubic_flattener (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], p0_x[26:3], p0_y[50:27], p1_x, p1_y, p2_x, p2_y[146:123], pad
	input  logic [151:0] s_axis_tdata,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// point_x[23:0], point_y[47:24]
	output logic [47:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import pcf_pkg::*;

	logic [TolW-1:0] tol_q;
	logic signed [CoordW-1:0] in_p [6];
	logic signed [CoordW-1:0] cv [8];
	logic signed [CoordW-1:0] end_x, end_y, ox, oy;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= TolW'(65536);
		else if (cfg_we) tol_q <= cfg_wdata;
	end

	always_comb begin
		for (int i = 0; i < 6; i++) in_p[i] = s_axis_tdata[3 + i*CoordW +: CoordW];
	end

	pcf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tdata[2:0]),
		.in_p,
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_x    (ox),
		.out_y    (oy),
		.out_kind (m_axis_tuser),
		.out_last (m_axis_tlast),
		.cmd, .sts, .cv, .end_x, .end_y
	);

	pcf_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.tol  (tol_q),
		.in_c (cv),
		.end_x, .end_y
	);

	assign m_axis_tdata = {oy, ox};
endmodule
